### hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Types, constants and per-byte step functions of the event-stream tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] EVENT_TXT [8] = '{8'h65, 8'h76, 8'h65, 8'h6e, 8'h74,
                                             8'h00, 8'h00, 8'h00};
    localparam logic [7:0] DATA_TXT  [8] = '{8'h64, 8'h61, 8'h74, 8'h61, 8'h00,
                                             8'h00, 8'h00, 8'h00};
    localparam logic [7:0] ID_TXT    [8] = '{8'h69, 8'h64, 8'h00, 8'h00, 8'h00,
                                             8'h00, 8'h00, 8'h00};
    localparam logic [2:0] EVENT_LEN = 3'd5;
    localparam logic [2:0] DATA_LEN  = 3'd4;
    localparam logic [2:0] ID_LEN    = 3'd2;
    localparam logic [2:0] NPOS_MAX  = 3'd7;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_NAME    = 3'd1,
        PH_COMMENT = 3'd2,
        PH_VFIRST  = 3'd3,
        PH_VALUE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        FC_IGNORE = 2'd0,
        FC_EVENT  = 2'd1,
        FC_DATA   = 2'd2,
        FC_ID     = 2'd3
    } t_field;

    typedef enum logic [3:0] {
        K_DATA     = 4'd0,
        K_NCLR     = 4'd1,
        K_NBYTE    = 4'd2,
        K_ICLR     = 4'd3,
        K_IBYTE    = 4'd4,
        K_ICOMMIT  = 4'd5,
        K_IDISCARD = 4'd6,
        K_DISPATCH = 4'd7,
        K_DROP     = 4'd8
    } t_kind;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] npos;
        logic [2:0] cand;      // bit0 event, bit1 data, bit2 id
        t_field     fcode;
        logic       held_cr;
        logic       has_data;
        logic       named;
        logic       id_nul;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       named;
    } t_token;

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_entry;

    typedef struct packed {
        t_state     st;
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_step;

    localparam t_state STATE_RESET = '{
        phase: PH_START, npos: 3'd0, cand: 3'b111, fcode: FC_IGNORE,
        held_cr: 1'b0, has_data: 1'b0, named: 1'b0, id_nul: 1'b0
    };

    function automatic t_step f_emit(t_step s, t_kind k, logic [7:0] v, logic nm);
        t_token t;
        t = '{kind: k, value: v, named: nm};
        if (s.cnt == 2'd0) begin
            s.tok0 = t;
            s.cnt  = 2'd1;
        end else if (s.cnt == 2'd1) begin
            s.tok1 = t;
            s.cnt  = 2'd2;
        end
        return s;
    endfunction

    function automatic t_step f_name_byte(t_step s, logic [7:0] b);
        if (!(s.st.npos < EVENT_LEN && b == EVENT_TXT[s.st.npos])) s.st.cand[0] = 1'b0;
        if (!(s.st.npos < DATA_LEN && b == DATA_TXT[s.st.npos]))   s.st.cand[1] = 1'b0;
        if (!(s.st.npos < ID_LEN && b == ID_TXT[s.st.npos]))       s.st.cand[2] = 1'b0;
        if (s.st.npos < NPOS_MAX) s.st.npos = s.st.npos + 3'd1;
        return s;
    endfunction

    function automatic t_step f_open_field(t_step s);
        s.st.fcode = FC_IGNORE;
        if (s.st.cand[0] && s.st.npos == EVENT_LEN) s.st.fcode = FC_EVENT;
        if (s.st.cand[1] && s.st.npos == DATA_LEN)  s.st.fcode = FC_DATA;
        if (s.st.cand[2] && s.st.npos == ID_LEN)    s.st.fcode = FC_ID;
        unique case (s.st.fcode)
            FC_EVENT: begin
                s = f_emit(s, K_NCLR, 8'd0, 1'b0);
                s.st.named = 1'b0;
            end
            FC_DATA: begin
                // separator before every data line but the first
                if (s.st.has_data) s = f_emit(s, K_DATA, CH_LF, 1'b0);
                s.st.has_data = 1'b1;
            end
            FC_ID: begin
                s = f_emit(s, K_ICLR, 8'd0, 1'b0);
                s.st.id_nul = 1'b0;
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_step f_close_field(t_step s);
        if (s.st.fcode == FC_ID) begin
            if (s.st.id_nul) s = f_emit(s, K_IDISCARD, 8'd0, 1'b0);
            else             s = f_emit(s, K_ICOMMIT, 8'd0, 1'b0);
        end
        return s;
    endfunction

    function automatic t_step f_value_byte(t_step s, logic [7:0] b);
        unique case (s.st.fcode)
            FC_EVENT: begin
                s = f_emit(s, K_NBYTE, b, 1'b0);
                s.st.named = 1'b1;
            end
            FC_DATA: s = f_emit(s, K_DATA, b, 1'b0);
            FC_ID: begin
                s = f_emit(s, K_IBYTE, b, 1'b0);
                if (b == 8'd0) s.st.id_nul = 1'b1;
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_step f_content(t_step s, logic [7:0] b);
        unique case (s.st.phase)
            PH_START: begin
                if (b == CH_COLON) begin
                    s.st.phase = PH_COMMENT;
                end else begin
                    s.st.phase = PH_NAME;
                    s = f_name_byte(s, b);
                end
            end
            PH_NAME: begin
                if (b == CH_COLON) begin
                    s = f_open_field(s);
                    s.st.phase = PH_VFIRST;
                end else begin
                    s = f_name_byte(s, b);
                end
            end
            PH_VFIRST: begin
                s.st.phase = PH_VALUE;
                if (b != CH_SPACE) s = f_value_byte(s, b);
            end
            PH_VALUE: s = f_value_byte(s, b);
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_step f_line_end(t_step s);
        if (s.st.phase == PH_START) begin
            if (s.st.has_data) s = f_emit(s, K_DISPATCH, 8'd0, s.st.named);
            else               s = f_emit(s, K_DROP, 8'd0, 1'b0);
            s.st.has_data = 1'b0;
            s.st.named    = 1'b0;
        end else if (s.st.phase == PH_NAME) begin
            s = f_open_field(s);
            s = f_close_field(s);
        end else if (s.st.phase == PH_VFIRST || s.st.phase == PH_VALUE) begin
            s = f_close_field(s);
        end
        s.st.phase = PH_START;
        s.st.npos  = 3'd0;
        s.st.cand  = 3'b111;
        s.st.fcode = FC_IGNORE;
        return s;
    endfunction

    // One raw byte: a CR is held until the next byte shows whether it ends a line.
    function automatic t_step f_step(t_state st, logic [7:0] b);
        t_step s;
        s    = '0;
        s.st = st;
        if (st.held_cr) begin
            s.st.held_cr = 1'b0;
            if (b == CH_LF) begin
                s = f_line_end(s);
            end else begin
                s = f_content(s, CH_CR);
                if (b == CH_CR) s.st.held_cr = 1'b1;
                else            s = f_content(s, b);
            end
        end else if (b == CH_CR) begin
            s.st.held_cr = 1'b1;
        end else if (b == CH_LF) begin
            s = f_line_end(s);
        end else begin
            s = f_content(s, b);
        end
        return s;
    endfunction

endpackage

### hdl/sse_stream_tokenizer_core.sv
// Output: the tokens of a byte are written to the token queue as the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one token and the output
// is not stalled; the single token output port drains a 4-entry token queue, so bytes
// yielding two tokens (held CR, id open/close) slow intake to the output rate.
// Reset: synchronous, active low; clears parser state and empties the token queue.
// ----------------------------------------------------------------------------
// sse_stream_tokenizer_core
// Event-stream tokenizer: one raw byte in per request, zero to two tokens out.
// ----------------------------------------------------------------------------
module sse_stream_tokenizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_stream_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_kind,
    output logic [7:0] o_value_byte,
    output logic       o_named,
    output logic       o_last
);
    import sst_pkg::*;

    t_state     r_state;
    t_entry     r_fifo [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;

    t_step  step_res;
    t_entry ent0;
    t_entry ent1;
    logic   in_acc;
    logic   out_acc;

    assign o_in_stall  = r_count > 3'd2;   // room for two tokens needed
    assign o_out_valid = r_count != 3'd0;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;

    always_comb begin
        step_res  = f_step(r_state, i_stream_byte);
        ent0.tok  = step_res.tok0;
        ent0.last = step_res.cnt == 2'd1;
        ent1.tok  = step_res.tok1;
        ent1.last = 1'b1;
        n_count   = r_count + (in_acc ? {1'b0, step_res.cnt} : 3'd0)
                  - (out_acc ? 3'd1 : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= STATE_RESET;
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (in_acc) begin
                r_state  <= step_res.st;
                r_wr_ptr <= r_wr_ptr + step_res.cnt;
            end
            if (out_acc) r_rd_ptr <= r_rd_ptr + 2'd1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (step_res.cnt != 2'd0) r_fifo[r_wr_ptr] <= ent0;
            if (step_res.cnt == 2'd2) r_fifo[r_wr_ptr + 2'd1] <= ent1;
        end
    end

    assign o_kind       = r_fifo[r_rd_ptr].tok.kind;
    assign o_value_byte = r_fifo[r_rd_ptr].tok.value;
    assign o_named      = r_fifo[r_rd_ptr].tok.named;
    assign o_last       = r_fifo[r_rd_ptr].last;

endmodule

### hdl/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks of the event-stream tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_stream_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_kind,
    input logic [7:0] o_value_byte,
    input logic       o_named,
    input logic       o_last
);
    import sst_pkg::*;

    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_stream_byte))
        else $error("request changed while stalled");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
                                       && $stable(o_value_byte)
                                       && $stable(o_named) && $stable(o_last))
        else $error("token dropped or changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= 4'(K_DROP))
        else $error("token kind out of range");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != 4'(K_DATA) && o_kind != 4'(K_NBYTE)
            && o_kind != 4'(K_IBYTE) |-> o_value_byte == 8'd0)
        else $error("value byte set on a non-byte token");

    a_named_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_named |-> o_kind == 4'(K_DISPATCH))
        else $error("named flag outside dispatch");

endmodule

bind sse_stream_tokenizer_core sst_checker u_sst_checker (.*);
